// ===== hw/rtl/bba_pkg.sv =====
// Package for the block bitmap allocator: sizes, command and status codes,
// register indexes, FSM state type and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package bba_pkg;

    localparam int WORD_W  = 64;
    localparam int POS_W   = 6;
    localparam int DEPTH   = 512;
    localparam int ADDR_W  = 9;
    localparam int IDX_W   = 15;
    localparam int LIM_W   = 16;
    localparam int SCAN_W  = ADDR_W + 1;
    localparam int MAPC_W  = 3;
    localparam int MAP_SHIFT = 13;

    localparam logic [MAPC_W-1:0] MAX_MAP_BLOCKS = 3'd4;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic REG_DATA_COUNT = 1'b0;
    localparam logic REG_MAP_COUNT  = 1'b1;

    localparam logic [LIM_W-1:0]  DATA_COUNT_RST = 16'd32768;
    localparam logic [MAPC_W-1:0] MAP_COUNT_RST  = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef enum logic [2:0] {
        RESP_NONE,
        RESP_RANGE,
        RESP_READ,
        RESP_WRITE,
        RESP_FOUND,
        RESP_EMPTY
    } resp_t;

    typedef struct packed {
        logic  clr_en;
        logic  load_item;
        logic  rd_item;
        logic  wr_item;
        logic  scan_en;
        resp_t resp;
    } dp_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] item_cmd;
        logic       in_range;
        logic       scan_hit;
        logic       scan_over;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// Controller FSM for the block bitmap allocator.
// Depends on bba_pkg; drives bba_dpath through dp_cmd_t, reads dp_stat_t.
`default_nettype none

module bba_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bba_pkg::dp_stat_t stat,
    output bba_pkg::dp_cmd_t       ctrl
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;
    logic            accept;

    assign accept = start && (state_reg == bba_pkg::S_IDLE);
    assign busy   = (state_reg != bba_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bba_pkg::S_DISPATCH;
                end
            end
            bba_pkg::S_DISPATCH:
            begin
                unique case (stat.item_cmd) inside
                    bba_pkg::CMD_READ, bba_pkg::CMD_WRITE:
                    begin
                        state_next = stat.in_range ? bba_pkg::S_EXEC : bba_pkg::S_IDLE;
                    end
                    bba_pkg::CMD_FIND:
                    begin
                        state_next = bba_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = bba_pkg::S_IDLE;
                    end
                endcase
            end
            bba_pkg::S_EXEC:
            begin
                state_next = bba_pkg::S_IDLE;
            end
            bba_pkg::S_SCAN:
            begin
                if (stat.scan_hit || stat.scan_over)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl           = '0;
        ctrl.resp      = bba_pkg::RESP_NONE;
        ctrl.load_item = accept;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                ctrl.clr_en = 1'b1;
            end
            bba_pkg::S_IDLE:
            begin
            end
            bba_pkg::S_DISPATCH:
            begin
                unique case (stat.item_cmd) inside
                    bba_pkg::CMD_READ, bba_pkg::CMD_WRITE:
                    begin
                        if (stat.in_range)
                        begin
                            ctrl.rd_item = 1'b1;
                        end
                        else
                        begin
                            ctrl.resp = bba_pkg::RESP_RANGE;
                        end
                    end
                    bba_pkg::CMD_FIND:
                    begin
                    end
                    default:
                    begin
                        ctrl.resp = bba_pkg::RESP_RANGE;
                    end
                endcase
            end
            bba_pkg::S_EXEC:
            begin
                if (stat.item_cmd == bba_pkg::CMD_WRITE)
                begin
                    ctrl.wr_item = 1'b1;
                    ctrl.resp    = bba_pkg::RESP_WRITE;
                end
                else
                begin
                    ctrl.resp = bba_pkg::RESP_READ;
                end
            end
            bba_pkg::S_SCAN:
            begin
                ctrl.scan_en = 1'b1;
                if (stat.scan_hit)
                begin
                    ctrl.resp = bba_pkg::RESP_FOUND;
                end
                else if (stat.scan_over)
                begin
                    ctrl.resp = bba_pkg::RESP_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_dpath.sv =====
// Datapath for the block bitmap allocator: bitmap word memory, item
// registers, range limit, scan pipeline, first-free encoder, result regs.
// Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none

module bba_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [1:0]                    cmd,
    input  wire logic [bba_pkg::IDX_W-1:0]     block_index,
    input  wire logic                          bit_value,
    input  wire logic [bba_pkg::LIM_W-1:0]     data_block_count,
    input  wire logic [bba_pkg::MAPC_W-1:0]    bitmap_block_count,
    input  wire bba_pkg::dp_cmd_t              ctrl,
    output bba_pkg::dp_stat_t                  stat,
    output logic                               done,
    output logic                               bit_state,
    output logic [bba_pkg::IDX_W-1:0]          found_index,
    output logic [1:0]                         status
);

    logic [bba_pkg::WORD_W-1:0] mem [bba_pkg::DEPTH];

    logic [1:0]                   cmd_reg;
    logic [bba_pkg::IDX_W-1:0]    idx_reg;
    logic                         val_reg;
    logic [bba_pkg::ADDR_W-1:0]   clr_cnt_reg;
    logic [bba_pkg::SCAN_W-1:0]   scan_addr_reg;
    logic                         pend_vld_reg;
    logic [bba_pkg::ADDR_W-1:0]   pend_addr_reg;
    logic [bba_pkg::WORD_W-1:0]   rdata_reg;
    logic                         done_reg;
    logic                         bit_state_reg;
    logic [bba_pkg::IDX_W-1:0]    found_index_reg;
    logic [1:0]                   status_reg;

    logic                         bit_state_next;
    logic [bba_pkg::IDX_W-1:0]    found_index_next;
    logic [1:0]                   status_next;

    logic [bba_pkg::MAPC_W-1:0]   maps;
    logic [bba_pkg::LIM_W-1:0]    map_lim;
    logic [bba_pkg::LIM_W-1:0]    lim;
    logic                         issue;
    logic [bba_pkg::LIM_W-1:0]    base_eval;
    logic [bba_pkg::LIM_W-1:0]    rem;
    logic [bba_pkg::WORD_W-1:0]   tail_mask;
    logic [bba_pkg::WORD_W-1:0]   free_bits;
    logic [bba_pkg::POS_W-1:0]    ffs_pos;
    logic [31:0]                  v32;
    logic [15:0]                  v16;
    logic [7:0]                   v8;
    logic [3:0]                   v4;
    logic [1:0]                   v2;

    logic                         mem_we;
    logic [bba_pkg::ADDR_W-1:0]   mem_waddr;
    logic [bba_pkg::WORD_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [bba_pkg::ADDR_W-1:0]   mem_raddr;

    // in-range limit: min(saturated map count * 8192, data block count)
    assign maps    = (bitmap_block_count > bba_pkg::MAX_MAP_BLOCKS) ?
                     bba_pkg::MAX_MAP_BLOCKS : bitmap_block_count;
    assign map_lim = {maps, {bba_pkg::MAP_SHIFT{1'b0}}};
    assign lim     = (map_lim > data_block_count) ? data_block_count : map_lim;

    // scan issues a word read while its base is below the limit
    assign issue = ({scan_addr_reg, {bba_pkg::POS_W{1'b0}}} < lim);

    assign base_eval = {1'b0, pend_addr_reg, {bba_pkg::POS_W{1'b0}}};
    assign rem       = lim - base_eval;
    assign tail_mask = (rem < bba_pkg::LIM_W'(bba_pkg::WORD_W)) ?
                       ~({bba_pkg::WORD_W{1'b1}} << rem[bba_pkg::POS_W-1:0]) :
                       {bba_pkg::WORD_W{1'b1}};
    assign free_bits = ~rdata_reg & tail_mask;

    // lowest set bit, halving tree
    always_comb
    begin
        ffs_pos[5] = ~(|free_bits[31:0]);
        v32        = ffs_pos[5] ? free_bits[63:32] : free_bits[31:0];
        ffs_pos[4] = ~(|v32[15:0]);
        v16        = ffs_pos[4] ? v32[31:16] : v32[15:0];
        ffs_pos[3] = ~(|v16[7:0]);
        v8         = ffs_pos[3] ? v16[15:8] : v16[7:0];
        ffs_pos[2] = ~(|v8[3:0]);
        v4         = ffs_pos[2] ? v8[7:4] : v8[3:0];
        ffs_pos[1] = ~(|v4[1:0]);
        v2         = ffs_pos[1] ? v4[3:2] : v4[1:0];
        ffs_pos[0] = ~v2[0];
    end

    assign stat.clr_done  = (clr_cnt_reg == bba_pkg::ADDR_W'(bba_pkg::DEPTH - 1));
    assign stat.item_cmd  = cmd_reg;
    assign stat.in_range  = ({1'b0, idx_reg} < lim);
    assign stat.scan_hit  = pend_vld_reg && (|free_bits);
    assign stat.scan_over = !pend_vld_reg && !issue;

    // memory port selection
    always_comb
    begin
        mem_we    = ctrl.clr_en || ctrl.wr_item;
        mem_waddr = ctrl.clr_en ? clr_cnt_reg : idx_reg[bba_pkg::IDX_W-1:bba_pkg::POS_W];
        mem_wdata = rdata_reg;
        mem_wdata[idx_reg[bba_pkg::POS_W-1:0]] = val_reg;
        if (ctrl.clr_en)
        begin
            mem_wdata = '0;
        end
        mem_re    = ctrl.rd_item || (ctrl.scan_en && issue);
        mem_raddr = ctrl.rd_item ? idx_reg[bba_pkg::IDX_W-1:bba_pkg::POS_W] :
                    scan_addr_reg[bba_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg <= cmd;
            idx_reg <= block_index;
            val_reg <= bit_value;
        end
        if (ctrl.scan_en)
        begin
            pend_addr_reg <= scan_addr_reg[bba_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            scan_addr_reg <= '0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.load_item)
            begin
                scan_addr_reg <= '0;
                pend_vld_reg  <= 1'b0;
            end
            else if (ctrl.scan_en)
            begin
                pend_vld_reg <= issue;
                if (issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
            end
        end
    end

    // result formatting
    always_comb
    begin
        bit_state_next   = 1'b0;
        found_index_next = '0;
        status_next      = bba_pkg::ST_OK;
        case (ctrl.resp)
            bba_pkg::RESP_RANGE: status_next = bba_pkg::ST_RANGE;
            bba_pkg::RESP_READ:  bit_state_next = rdata_reg[idx_reg[bba_pkg::POS_W-1:0]];
            bba_pkg::RESP_FOUND: found_index_next = {pend_addr_reg, ffs_pos};
            bba_pkg::RESP_EMPTY: status_next = bba_pkg::ST_NONE;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.resp != bba_pkg::RESP_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        bit_state_reg   <= bit_state_next;
        found_index_reg <= found_index_next;
        status_reg      <= status_next;
    end

    assign done        = done_reg;
    assign bit_state   = bit_state_reg;
    assign found_index = found_index_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/block_bitmap_allocator_core.sv =====
// Top level of the block bitmap allocator: APB config registers, controller
// and datapath. Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// Usage:
//   Items: drive cmd, block_index, bit_value with start high; the item is
//   taken at a rising edge where start is high and busy is low. cmd selects
//   read bit, write bit or find first free block.
//   Results: one per item, shown on bit_state, found_index and status for
//   exactly one cycle while done is high. The receiver cannot stall.
//   Sequence from the accept edge to the done cycle:
//     read / write in range           : DISPATCH, EXEC, result registers
//     out of range or unused command  : DISPATCH, result registers
//     find                            : DISPATCH, then SCAN while words are
//                                       read and checked, result registers;
//                                       at most 512 words are read
//   The bitmap lives in one word memory (64 bits x 512) with separate write
//   and read ports; find reads one word per cycle, so the scan length sets
//   its rate. busy stays high until the result is registered; a new item may
//   be taken in the same cycle that done is shown.
//   Reset: a clearing pass writes all 512 words to zero (every block free)
//   with busy high. Config registers reset to 32768 data blocks and 4 map
//   blocks and may be written over APB whenever no item is in flight.
//   data_block_count at byte 0, bitmap_block_count at byte 4.
`default_nettype none

module block_bitmap_allocator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    cmd,
    input  wire logic [bba_pkg::IDX_W-1:0]     block_index,
    input  wire logic                          bit_value,
    output logic                               done,
    output logic                               bit_state,
    output logic [bba_pkg::IDX_W-1:0]          found_index,
    output logic [1:0]                         status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [bba_pkg::LIM_W-1:0]  data_count_reg;
    logic [bba_pkg::MAPC_W-1:0] map_count_reg;
    logic                       cfg_wr;
    logic                       reg_sel;

    bba_pkg::dp_cmd_t  ctrl;
    bba_pkg::dp_stat_t stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];   // word-aligned register select

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_count_reg <= bba_pkg::DATA_COUNT_RST;
            map_count_reg  <= bba_pkg::MAP_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                bba_pkg::REG_DATA_COUNT: data_count_reg <= pwdata[bba_pkg::LIM_W-1:0];
                bba_pkg::REG_MAP_COUNT:  map_count_reg  <= pwdata[bba_pkg::MAPC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            bba_pkg::REG_DATA_COUNT: prdata = {16'd0, data_count_reg};
            bba_pkg::REG_MAP_COUNT:  prdata = {29'd0, map_count_reg};
            default:
            begin
            end
        endcase
    end

    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    bba_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .block_index        (block_index),
        .bit_value          (bit_value),
        .data_block_count   (data_count_reg),
        .bitmap_block_count (map_count_reg),
        .ctrl               (ctrl),
        .stat               (stat),
        .done               (done),
        .bit_state          (bit_state),
        .found_index        (found_index),
        .status             (status)
    );

endmodule

`default_nettype wire
